// ===== hdl/udkc_pkg.sv =====
// ----------------------------------------------------------------------------
// udkc_pkg
// Shared constants, configuration type and segment decode for the up/down
// key counter with seven-segment scan.
// ----------------------------------------------------------------------------
package udkc_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int ScanW       = 3;
    localparam int CountW      = 7;
    localparam int TimerW      = 12;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 12;

    localparam logic [CountW-1:0] MaxCount = 7'd99;

    localparam logic [CfgIdxW-1:0] CfgDebounce  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgLongPress = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgRepeat    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgLimit     = 3'd3;

    typedef struct packed {
        logic [7:0]        debounce_ticks;
        logic [TimerW-1:0] long_press_ticks;
        logic [7:0]        repeat_ticks;
        logic [CountW-1:0] count_limit;
    } t_cfg;

    function automatic logic [7:0] seg_decode(input logic [3:0] nib);
        logic [7:0] seg;
        case (nib)
            4'h0: seg = 8'h3f;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5b;
            4'h3: seg = 8'h4f;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6d;
            4'h6: seg = 8'h7d;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7f;
            4'h9: seg = 8'h6f;
            4'ha: seg = 8'h77;
            4'hb: seg = 8'h7c;
            4'hc: seg = 8'h39;
            4'hd: seg = 8'h5e;
            4'he: seg = 8'h79;
            4'hf: seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== hdl/udkc_key_fsm.sv =====
// ----------------------------------------------------------------------------
// udkc_key_fsm
// Debounce, long-press and auto-repeat sequencer with the saturating count.
// Gives the count after the current tick's key handling.
// ----------------------------------------------------------------------------
module udkc_key_fsm
    import udkc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_up_key_n,
    input  logic              i_down_key_n,
    input  t_cfg              i_cfg,
    output logic [CountW-1:0] o_count_next
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_UP_DEB  = 3'd1,
        PH_UP_HOLD = 3'd2,
        PH_UP_REP  = 3'd3,
        PH_DN_DEB  = 3'd4,
        PH_DN_HOLD = 3'd5,
        PH_DN_REP  = 3'd6
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [TimerW-1:0]  r_timer, n_timer;
    logic [CountW-1:0]  r_counter, n_counter;

    logic              up_pressed;
    logic              dn_pressed;
    logic              up_dir;
    logic              pressed;
    logic              do_step;
    logic [TimerW-1:0] timer_inc;
    logic [CountW-1:0] lim;

    assign up_pressed = ~i_up_key_n;
    assign dn_pressed = ~i_down_key_n;
    assign up_dir     = (r_phase == PH_IDLE) || (r_phase == PH_UP_DEB) ||
                        (r_phase == PH_UP_HOLD) || (r_phase == PH_UP_REP);
    assign pressed    = up_dir ? up_pressed : dn_pressed;
    assign timer_inc  = (r_timer == {TimerW{1'b1}}) ? r_timer : r_timer + 1'b1;
    assign lim        = (i_cfg.count_limit > MaxCount) ? MaxCount : i_cfg.count_limit;

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        do_step = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (up_pressed) begin
                    n_phase = PH_UP_DEB;
                    n_timer = '0;
                end else if (dn_pressed) begin
                    n_phase = PH_DN_DEB;
                    n_timer = '0;
                end
            end
            PH_UP_DEB, PH_DN_DEB: begin
                n_timer = timer_inc;
                if (timer_inc >= {4'd0, i_cfg.debounce_ticks}) begin
                    n_phase = !pressed ? PH_IDLE : (up_dir ? PH_UP_HOLD : PH_DN_HOLD);
                    n_timer = '0;
                end
            end
            PH_UP_HOLD, PH_DN_HOLD: begin
                if (!pressed) begin
                    do_step = 1'b1;
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= i_cfg.long_press_ticks) begin
                        do_step = 1'b1;
                        n_phase = up_dir ? PH_UP_REP : PH_DN_REP;
                        n_timer = '0;
                    end
                end
            end
            PH_UP_REP, PH_DN_REP: begin
                if (!pressed) begin
                    do_step = 1'b1;
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= {4'd0, i_cfg.repeat_ticks}) begin
                        do_step = 1'b1;
                        n_timer = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_timer = '0;
            end
        endcase
    end

    always_comb begin
        n_counter = r_counter;
        if (do_step) begin
            if (up_dir) begin
                if (r_counter < lim) n_counter = r_counter + 1'b1;
            end else begin
                if (r_counter != '0) n_counter = r_counter - 1'b1;
            end
        end
    end

    assign o_count_next = n_counter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_counter <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_counter <= n_counter;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counter <= MaxCount)
        else $error("count above maximum");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_counter))
        else $error("count moved without a beat");

    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_timer == '0))
        else $error("timer running while idle");

endmodule

// ===== hdl/updown_key_counter_segment_scan_unit.sv =====
// ----------------------------------------------------------------------------
// updown_key_counter_segment_scan_unit
// Up/down key counter with debounce, auto-repeat and a seven-segment scan.
// ----------------------------------------------------------------------------
// Each input beat is one scan tick carrying the two active-low key levels.
// A beat can be accepted every clock cycle while the output register is free
// or being taken; its result (digit select, segment code and count) appears
// in the output register on the next cycle and stays until taken, while the
// next beat is accepted in the same cycle the result is taken. The output
// register is the only stage, so throughput is one tick per cycle while the
// receiver keeps taking results. Configuration registers are written through
// the cfg channel, always ready; write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module updown_key_counter_segment_scan_unit
    import udkc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_up_key_n,
    input  logic                i_down_key_n,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_digit_select_n,
    output logic [7:0]          o_segment_code,
    output logic [CountW-1:0]   o_count_value,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_cfg              r_cfg;
    logic [ScanW-1:0]  r_scan, n_scan;
    logic              r_out_valid;
    logic [7:0]        r_sel, r_seg;
    logic [CountW-1:0] r_cnt;

    logic              accept;
    logic [CountW-1:0] count_next;
    logic [14:0]       tens_prod;
    logic [3:0]        tens;
    logic [3:0]        ones;
    logic [7:0]        n_seg;
    logic [7:0]        n_sel;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    udkc_key_fsm u_key (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (accept),
        .i_up_key_n   (i_up_key_n),
        .i_down_key_n (i_down_key_n),
        .i_cfg        (r_cfg),
        .o_count_next (count_next)
    );

    // divide by ten: multiply by 205, shift by 11
    assign tens_prod = {8'd0, count_next} * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = 4'(count_next - CountW'({tens, 3'd0} + {tens, 1'b0}));

    always_comb begin
        case (r_scan)
            3'd0:    n_seg = seg_decode(tens);
            3'd1:    n_seg = seg_decode(ones);
            default: n_seg = 8'h00;
        endcase
    end

    assign n_sel  = ~(8'd1 << r_scan);
    assign n_scan = (r_scan == ScanW'(DIGIT_COUNT - 1)) ? '0 : r_scan + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= 8'd5;
            r_cfg.long_press_ticks <= 12'd1000;
            r_cfg.repeat_ticks     <= 8'd25;
            r_cfg.count_limit      <= 7'd99;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgDebounce:  r_cfg.debounce_ticks   <= i_cfg_data[7:0];
                CfgLongPress: r_cfg.long_press_ticks <= i_cfg_data;
                CfgRepeat:    r_cfg.repeat_ticks     <= i_cfg_data[7:0];
                CfgLimit:     r_cfg.count_limit      <= i_cfg_data[CountW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_scan      <= n_scan;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel <= n_sel;
            r_seg <= n_seg;
            r_cnt <= count_next;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_digit_select_n = r_sel;
    assign o_segment_code   = r_seg;
    assign o_count_value    = r_cnt;

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= ScanW'(DIGIT_COUNT - 1))
        else $error("scan position out of range");

    a_sel_onecold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot(~o_digit_select_n))
        else $error("digit select not one-cold");

    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_digit_select_n[1:0] == 2'b11) |-> (o_segment_code == 8'h00))
        else $error("unused digit not blank");

endmodule

// ===== tb/sv/updown_key_counter_segment_scan_unit_tb.sv =====
// ----------------------------------------------------------------------------
// updown_key_counter_segment_scan_unit_tb
// Self-checking bench for the up/down key counter with seven-segment scan.
// A scoreboard class mirrors the key debounce, hold and auto-repeat logic,
// the saturating count and the digit scan, and checks every output beat in
// order. Key gestures with random timing run under several register
// settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module updown_key_counter_segment_scan_unit_tb;
    import udkc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_TICKS  = 40;
    localparam int PHASE_COUNT  = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int TimerMax     = (1 << TimerW) - 1;

    typedef enum logic [2:0] {
        KEY_IDLE, UP_SETTLE, UP_HELD, UP_AUTO, DN_SETTLE, DN_HELD, DN_AUTO
    } t_key_phase;

    typedef enum int {GESTURE_UP, GESTURE_DOWN, GESTURE_BOTH, GESTURE_NOISE} t_gesture;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} t_ready_mode;

    class t_tick_scoreboard;
        typedef struct packed {
            logic [7:0]        select_n;
            logic [7:0]        segments;
            logic [CountW-1:0] count;
        } t_tick_view;

        t_cfg         cfg;
        t_key_phase   phase;
        int unsigned  hold_timer;
        int unsigned  count;
        int unsigned  scan_pos;
        t_tick_view   display_q[$];
        int           errors;
        logic [7:0]   seg_hex [16];

        function new();
            seg_hex = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
                        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71};
            cfg.debounce_ticks   = 8'd5;
            cfg.long_press_ticks = 12'd1000;
            cfg.repeat_ticks     = 8'd25;
            cfg.count_limit      = 7'd99;
            phase      = KEY_IDLE;
            hold_timer = 0;
            count      = 0;
            scan_pos   = 0;
            errors     = 0;
        endfunction

        function void write_reg(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
            case (idx)
                CfgDebounce:  cfg.debounce_ticks   = data[7:0];
                CfgLongPress: cfg.long_press_ticks = data[TimerW-1:0];
                CfgRepeat:    cfg.repeat_ticks     = data[7:0];
                CfgLimit:     cfg.count_limit      = data[CountW-1:0];
                default: ;
            endcase
        endfunction

        function void step_count(input bit up);
            int unsigned lim;
            lim = (cfg.count_limit > MaxCount) ? MaxCount : cfg.count_limit;
            if (up) begin
                if (count < lim) count++;
            end else begin
                if (count > 0) count--;
            end
        endfunction

        function void advance_timer();
            if (hold_timer < TimerMax) hold_timer++;
        endfunction

        function void note_tick(input bit up_n, input bit dn_n);
            bit          up_p;
            bit          dn_p;
            bit          up_dir;
            bit          pressed;
            t_key_phase  settle;
            t_tick_view  view;
            up_p    = !up_n;
            dn_p    = !dn_n;
            up_dir  = (phase <= UP_AUTO);
            pressed = up_dir ? up_p : dn_p;
            settle  = up_dir ? UP_SETTLE : DN_SETTLE;
            if (phase == KEY_IDLE) begin
                if (up_p) begin
                    phase      = UP_SETTLE;
                    hold_timer = 0;
                end else if (dn_p) begin
                    phase      = DN_SETTLE;
                    hold_timer = 0;
                end
            end else if (phase == settle) begin
                advance_timer();
                if (hold_timer >= cfg.debounce_ticks) begin
                    if (pressed) phase = t_key_phase'(settle + 1);
                    else phase = KEY_IDLE;
                    hold_timer = 0;
                end
            end else if (!pressed) begin
                step_count(up_dir);
                phase      = KEY_IDLE;
                hold_timer = 0;
            end else begin
                advance_timer();
                if (phase == UP_HELD || phase == DN_HELD) begin
                    if (hold_timer >= cfg.long_press_ticks) begin
                        step_count(up_dir);
                        phase      = t_key_phase'(phase + 1);
                        hold_timer = 0;
                    end
                end else if (hold_timer >= cfg.repeat_ticks) begin
                    step_count(up_dir);
                    hold_timer = 0;
                end
            end

            view.select_n = ~(8'd1 << scan_pos);
            if (scan_pos == 0) view.segments = seg_hex[(count / 10) % 16];
            else if (scan_pos == 1) view.segments = seg_hex[(count % 10) % 16];
            else view.segments = 8'h00;
            view.count = count[CountW-1:0];
            display_q.push_back(view);
            scan_pos = (scan_pos + 1) % DIGIT_COUNT;
        endfunction

        function void check_result(input logic [7:0] sel, input logic [7:0] seg,
                                   input logic [CountW-1:0] cnt);
            t_tick_view want;
            if (display_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected beat: sel %h seg %h count %0d", sel, seg, cnt);
                return;
            end
            want = display_q.pop_front();
            if (want.select_n !== sel || want.segments !== seg || want.count !== cnt) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"mismatch: sel exp %h got %h, seg exp %h got %h, ",
                              "count exp %0d got %0d"},
                             want.select_n, sel, want.segments, seg, want.count, cnt);
            end
        endfunction

        function int pending();
            return display_q.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                i_up_key_n     = 1'b1;
    logic                i_down_key_n   = 1'b1;
    logic                i_out_ready    = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index    = '0;
    logic [CfgDataW-1:0] i_cfg_data     = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [7:0]          o_digit_select_n;
    logic [7:0]          o_segment_code;
    logic [CountW-1:0]   o_count_value;
    logic                o_cfg_ready;

    t_tick_scoreboard board;
    bit               hold_req;
    int               burst_left;
    int               sent_ticks;
    int               cycle_count;

    updown_key_counter_segment_scan_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_up_key_n       (i_up_key_n),
        .i_down_key_n     (i_down_key_n),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digit_select_n (o_digit_select_n),
        .o_segment_code   (o_segment_code),
        .o_count_value    (o_count_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_tick(input bit up_n, input bit dn_n);
        int gap;
        i_in_valid   <= 1'b1;
        i_up_key_n   <= up_n;
        i_down_key_n <= dn_n;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_tick(up_n, dn_n);
        sent_ticks++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input int deb, input int lng, input int rep, input int lim);
        logic [CfgDataW-1:0] data;
        data = CfgDataW'($urandom);
        data[7:0] = 8'(deb);
        write_cfg(CfgDebounce, data);
        write_cfg(CfgLongPress, CfgDataW'(lng));
        data = CfgDataW'($urandom);
        data[7:0] = 8'(rep);
        write_cfg(CfgRepeat, data);
        data = CfgDataW'($urandom);
        data[CountW-1:0] = CountW'(lim);
        write_cfg(CfgLimit, data);
        if ($urandom_range(0, 2) == 0)
            write_cfg(CfgIdxW'($urandom_range(CfgLimit + 1, (1 << CfgIdxW) - 1)),
                      CfgDataW'($urandom));
    endtask

    task automatic random_settings();
        int deb;
        int lng;
        int rep;
        int lim;
        case ($urandom_range(0, 7))
            0:       deb = 0;
            1:       deb = 255;
            default: deb = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 7))
            0:       lng = 0;
            1:       lng = TimerMax;
            default: lng = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0:       rep = 0;
            1:       rep = 255;
            default: rep = $urandom_range(1, 6);
        endcase
        lim = ($urandom_range(0, 3) == 0) ? int'(MaxCount) : $urandom_range(0, 127);
        write_settings(deb, lng, rep, lim);
    endtask

    task automatic run_gesture(input t_gesture kind, input int hold_len);
        bit other;
        for (int i = 0; i < hold_len; i++) begin
            other = ($urandom_range(0, 3) == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
            case (kind)
                GESTURE_UP:   send_tick(1'b0, other);
                GESTURE_DOWN: send_tick(other, 1'b0);
                GESTURE_BOTH: send_tick(1'b0, 1'b0);
                default:      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
        end
        repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b1);
    endtask

    initial begin
        t_ready_mode mode;
        int          mode_left;
        int          hold_left;
        mode      = READY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_result(o_digit_select_n, o_segment_code, o_count_value);
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    READY_ALWAYS: i_out_ready <= 1'b1;
                    READY_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: i_out_ready <= ($urandom_range(0, 7) != 0);
                    default:      i_out_ready <= (mode_left % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int phase_start;
        board      = new();
        hold_req   = 1'b0;
        burst_left = 0;
        sent_ticks = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: confirm and release, both keys, release while settling
        send_tick(1'b1, 1'b1);
        repeat (6) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        repeat (6) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        repeat (4) send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b1, 1'b1);
        drain();

        // zero timers and zero limit: count held above the limit, then stepped down
        write_settings(0, 0, 0, 0);
        repeat (3) send_tick(1'b0, 1'b1);
        repeat (4) send_tick(1'b1, 1'b0);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       write_settings(1, 1, 1, int'(MaxCount));
                1:       write_settings(255, TimerMax, 255, 127);
                default: random_settings();
            endcase
            phase_start = sent_ticks;
            if (p == 0) begin
                run_gesture(GESTURE_UP, 120);
                run_gesture(GESTURE_DOWN, 40);
            end
            if (p == 3) hold_req = 1'b1;
            while (sent_ticks - phase_start < PHASE_TICKS) begin
                run_gesture(t_gesture'($urandom_range(0, 3)),
                            ($urandom_range(0, 5) == 0) ? $urandom_range(40, 300)
                                                        : $urandom_range(1, 40));
            end
            drain();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/udkc_pkg.sv
hdl/udkc_key_fsm.sv
hdl/updown_key_counter_segment_scan_unit.sv
tb/sv/updown_key_counter_segment_scan_unit_tb.sv
